[rtl/generator_auto_start_sequencer_core_macros.svh]
// Assertion helpers shared by the sequencer RTL.
// Every check samples on clk_i and is off while rst_ni is low.
`ifndef GENERATOR_AUTO_START_SEQUENCER_CORE_MACROS_SVH
`define GENERATOR_AUTO_START_SEQUENCER_CORE_MACROS_SVH

// General clocked check.
`define GASS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds.
`define GASS_ASSERT_NEVER(lbl, cond, msg) \
  `GASS_ASSERT(lbl, !(cond), msg)

`endif

[rtl/gass_pkg.sv]
// ----------------------------------------------------------------------------
// gass_pkg
// Types, codes and reset values for the generator auto-start sequencer.
// ----------------------------------------------------------------------------
package gass_pkg;

  localparam int unsigned TIMER_BITS_DEF = 16;
  localparam int unsigned DUR_W          = 16;
  localparam int unsigned VOLT_W         = 13;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned CFG_DATA_W     = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_WAIT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PREHEAT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CRANK   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PAUSE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ROUNDS  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_GOOD_V  = 3'd6;

  // Configuration reset values.
  localparam logic [DUR_W-1:0]  RST_WAIT_MS    = 16'd5000;
  localparam logic [DUR_W-1:0]  RST_PREHEAT_MS = 16'd5000;
  localparam logic [DUR_W-1:0]  RST_CRANK_MS   = 16'd5000;
  localparam logic [DUR_W-1:0]  RST_SETTLE_MS  = 16'd1000;
  localparam logic [DUR_W-1:0]  RST_PAUSE_MS   = 16'd5000;
  localparam logic [3:0]        RST_ROUNDS     = 4'd5;
  localparam logic [VOLT_W-1:0] RST_GOOD_V     = 13'd2000;

  // Request modes.
  localparam logic [2:0] MODE_TICK  = 3'd0;
  localparam logic [2:0] MODE_START = 3'd1;
  localparam logic [2:0] MODE_STOP  = 3'd2;
  localparam logic [2:0] MODE_FORCE = 3'd3;
  localparam logic [2:0] MODE_OFF   = 3'd4;

  // Sequence phases; code seven is never entered.
  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_WAIT    = 3'd1;
  localparam logic [2:0] PH_PREHEAT = 3'd2;
  localparam logic [2:0] PH_CRANK   = 3'd3;
  localparam logic [2:0] PH_SETTLE  = 3'd4;
  localparam logic [2:0] PH_ABORT   = 3'd5;
  localparam logic [2:0] PH_PAUSE   = 3'd6;
  localparam logic [2:0] PH_SEVEN   = 3'd7;

  // Relay bit masks.
  localparam logic [3:0] RLY_GLOW_A   = 4'b0001;
  localparam logic [3:0] RLY_GLOW_B   = 4'b0010;
  localparam logic [3:0] RLY_TRANSFER = 4'b0100;
  localparam logic [3:0] RLY_STARTER  = 4'b1000;
  localparam logic [3:0] RLY_GLOW     = RLY_GLOW_A | RLY_GLOW_B;

  localparam logic [3:0] ATTEMPT_MAX = 4'd15;

  typedef struct packed {
    logic [DUR_W-1:0]  wait_ms;
    logic [DUR_W-1:0]  preheat_ms;
    logic [DUR_W-1:0]  crank_ms;
    logic [DUR_W-1:0]  settle_ms;
    logic [DUR_W-1:0]  pause_ms;
    logic [3:0]        max_rounds;
    logic [VOLT_W-1:0] good_v;
  } cfg_t;

  typedef struct packed {
    logic [2:0]        mode;
    logic [1:0]        relay_index;
    logic              grid_lost;
    logic              voltage_valid;
    logic [VOLT_W-1:0] voltage_decivolts;
  } item_t;

  typedef struct packed {
    logic       glow_relay_a;
    logic       glow_relay_b;
    logic       transfer_relay;
    logic       starter_relay;
    logic       started_ok;
    logic [2:0] phase;
    logic [3:0] attempts_used;
  } res_t;

endpackage

[rtl/gass_cfg.sv]
// ----------------------------------------------------------------------------
// gass_cfg
// Configuration register file with write port and reset defaults.
// ----------------------------------------------------------------------------
module gass_cfg
  import gass_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WAIT:    cfg_d.wait_ms    = cfg_data_i;
        CFG_PREHEAT: cfg_d.preheat_ms = cfg_data_i;
        CFG_CRANK:   cfg_d.crank_ms   = cfg_data_i;
        CFG_SETTLE:  cfg_d.settle_ms  = cfg_data_i;
        CFG_PAUSE:   cfg_d.pause_ms   = cfg_data_i;
        CFG_ROUNDS:  cfg_d.max_rounds = cfg_data_i[3:0];
        CFG_GOOD_V:  cfg_d.good_v     = cfg_data_i[VOLT_W-1:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wait_ms    <= RST_WAIT_MS;
      cfg_q.preheat_ms <= RST_PREHEAT_MS;
      cfg_q.crank_ms   <= RST_CRANK_MS;
      cfg_q.settle_ms  <= RST_SETTLE_MS;
      cfg_q.pause_ms   <= RST_PAUSE_MS;
      cfg_q.max_rounds <= RST_ROUNDS;
      cfg_q.good_v     <= RST_GOOD_V;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/gass_seq.sv]
// ----------------------------------------------------------------------------
// gass_seq
// Sequencer state registers and the next-state logic.
// ----------------------------------------------------------------------------
module gass_seq
  import gass_pkg::*;
#(
  parameter int unsigned TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  item_t item_i,
  input  cfg_t  cfg_i,
  output res_t  res_o
);

  localparam int unsigned CMP_W = (TIMER_BITS > DUR_W) ? TIMER_BITS : DUR_W;

  typedef struct packed {
    logic [2:0]            phase;
    logic [TIMER_BITS-1:0] elapsed;
    logic [3:0]            attempts;
    logic                  success;
    logic                  debug;
    logic [3:0]            relays;
  } st_t;

  st_t st_q, st_d;

  // A saturated timer counts as expired for any duration.
  function automatic logic expired(logic [TIMER_BITS-1:0] e, logic [DUR_W-1:0] d);
    return (CMP_W'(e) > CMP_W'(d)) || (e == {TIMER_BITS{1'b1}});
  endfunction

  function automatic st_t seq_fn(st_t s, logic grid, logic vv, logic [VOLT_W-1:0] volts);
    st_t r;
    r = s;
    case (s.phase)
      PH_IDLE: begin
        r.elapsed = '0;
        r.phase   = PH_WAIT;
      end
      PH_WAIT: begin
        if ((s.attempts < cfg_i.max_rounds) && expired(s.elapsed, cfg_i.wait_ms) && grid) begin
          r.relays  = r.relays | RLY_GLOW;
          r.elapsed = '0;
          r.phase   = PH_PREHEAT;
        end
        if (s.debug) begin
          r.relays  = r.relays | RLY_GLOW;
          r.elapsed = '0;
          r.phase   = PH_PREHEAT;
        end
      end
      PH_PREHEAT: begin
        if (expired(s.elapsed, cfg_i.preheat_ms)) begin
          r.relays  = r.relays | RLY_STARTER;
          r.elapsed = '0;
          r.phase   = PH_CRANK;
        end
      end
      PH_CRANK: begin
        // A reading that is present but low keeps checking every item.
        if (expired(s.elapsed, cfg_i.crank_ms)) begin
          r.relays = r.relays & ~RLY_STARTER;
          if (!vv) begin
            r.phase   = PH_ABORT;
            r.elapsed = '0;
          end else if (volts >= cfg_i.good_v) begin
            r.phase   = PH_SETTLE;
            r.elapsed = '0;
          end
        end
      end
      PH_SETTLE: begin
        if (expired(s.elapsed, cfg_i.settle_ms)) begin
          r.relays  = r.relays & ~RLY_STARTER;
          r.success = 1'b1;
        end
      end
      PH_ABORT: begin
        if (expired(s.elapsed, cfg_i.settle_ms)) begin
          r.relays  = r.relays & ~RLY_GLOW;
          r.elapsed = '0;
          r.phase   = PH_PAUSE;
        end
      end
      PH_PAUSE: begin
        // The wait timer is not restarted here.
        if (expired(s.elapsed, cfg_i.pause_ms)) begin
          r.phase = PH_WAIT;
          if (s.attempts < ATTEMPT_MAX) begin
            r.attempts = s.attempts + 4'd1;
          end
        end
      end
      default: begin
        r.relays = '0;
        r.phase  = PH_IDLE;
      end
    endcase
    return r;
  endfunction

  always_comb begin
    st_t s;
    s = st_q;
    if ((item_i.mode == MODE_TICK) && (s.elapsed != {TIMER_BITS{1'b1}})) begin
      s.elapsed = s.elapsed + TIMER_BITS'(1);
    end
    case (item_i.mode)
      MODE_START: begin
        s.debug = 1'b1;
        s.phase = PH_WAIT;
      end
      MODE_STOP: begin
        s.debug = 1'b0;
        s.phase = PH_IDLE;
      end
      MODE_FORCE: s.relays = s.relays | (RLY_GLOW_A << item_i.relay_index);
      MODE_OFF:   s.relays = '0;
      default:    s.relays = s.relays;
    endcase
    if (!s.debug) begin
      if (item_i.grid_lost) begin
        if (!s.success) begin
          s.relays = s.relays | RLY_TRANSFER;
          s = seq_fn(s, item_i.grid_lost, item_i.voltage_valid, item_i.voltage_decivolts);
        end
      end else begin
        s.attempts = '0;
        s.phase    = PH_IDLE;
        s.relays   = '0;
        s.success  = 1'b0;
      end
    end
    if (s.phase != PH_IDLE) begin
      s = seq_fn(s, item_i.grid_lost, item_i.voltage_valid, item_i.voltage_decivolts);
    end
    st_d = s;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (en_i) begin
      st_q <= st_d;
    end
  end

  // The state after an item is its result, so the state register is the
  // result register.
  assign res_o.glow_relay_a   = st_q.relays[0];
  assign res_o.glow_relay_b   = st_q.relays[1];
  assign res_o.transfer_relay = st_q.relays[2];
  assign res_o.starter_relay  = st_q.relays[3];
  assign res_o.started_ok     = st_q.success;
  assign res_o.phase          = st_q.phase;
  assign res_o.attempts_used  = st_q.attempts;

endmodule

[rtl/generator_auto_start_sequencer_core.sv]
// ----------------------------------------------------------------------------
// generator_auto_start_sequencer_core
// Generator auto-start sequencer: tick and command requests in, relay drives
// and sequence status out, one result per request.
// ----------------------------------------------------------------------------
//   channel  handshake                  payload
//   in       in_valid_i / in_stall_o    mode, relay index, grid, voltage
//   out      out_valid_o / out_stall_i  four relays, started_ok, phase, attempts
//   cfg      cfg_we_i                   cfg_idx_i, cfg_data_i
//
// A request is captured in the input register and its result is registered in
// the state register when it advances; one request per cycle is sustained
// while the output is not stalled.
// Reset clears the sequence state and loads the default timings.
// While the result is stalled, the input register holds one more request and
// then stalls the input side.
module generator_auto_start_sequencer_core
  import gass_pkg::*;
#(
  parameter int unsigned TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [2:0]            mode_i,
  input  logic [1:0]            relay_index_i,
  input  logic                  grid_lost_i,
  input  logic                  voltage_valid_i,
  input  logic [VOLT_W-1:0]     voltage_decivolts_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  glow_relay_a_o,
  output logic                  glow_relay_b_o,
  output logic                  transfer_relay_o,
  output logic                  starter_relay_o,
  output logic                  started_ok_o,
  output logic [2:0]            phase_o,
  output logic [3:0]            attempts_used_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

`include "generator_auto_start_sequencer_core_macros.svh"

  logic  in_vld_q, in_vld_d;
  logic  out_vld_q, out_vld_d;
  item_t item_q;
  logic  in_acc, adv;
  cfg_t  cfg;
  res_t  res;

  assign adv        = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !adv;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_vld_d   = in_acc || (in_vld_q && !adv);
  assign out_vld_d  = adv || (out_vld_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q.mode              <= mode_i;
      item_q.relay_index       <= relay_index_i;
      item_q.grid_lost         <= grid_lost_i;
      item_q.voltage_valid     <= voltage_valid_i;
      item_q.voltage_decivolts <= voltage_decivolts_i;
    end
  end

  gass_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  gass_seq #(
    .TIMER_BITS (TIMER_BITS)
  ) u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  assign out_valid_o      = out_vld_q;
  assign glow_relay_a_o   = res.glow_relay_a;
  assign glow_relay_b_o   = res.glow_relay_b;
  assign transfer_relay_o = res.transfer_relay;
  assign starter_relay_o  = res.starter_relay;
  assign started_ok_o     = res.started_ok;
  assign phase_o          = res.phase;
  assign attempts_used_o  = res.attempts_used;

  `GASS_ASSERT(a_state_holds, !adv |=> $stable(res), "state changed without a request")
  `GASS_ASSERT(a_stall_has_item, in_stall_o |-> in_vld_q, "input stalled with an empty input register")
  `GASS_ASSERT(a_adv_gives_result, adv |=> out_vld_q, "request advanced without a result")
  `GASS_ASSERT_NEVER(a_no_phase_seven, res.phase == PH_SEVEN, "sequencer entered phase seven")

endmodule
